/* rtl/cop_pkg.sv */
`timescale 1ns / 1ps

package cop_pkg;

	localparam int AXIS_W    = 3;
	localparam int SAMPLE_W  = 32;
	localparam int CUR_W     = 32;
	localparam int LIMIT_W   = 63;
	localparam int ACC_W     = 64;
	localparam int ACC_SHIFT = 24;
	localparam int INC_W     = 2 * CUR_W - ACC_SHIFT;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 64;

	localparam logic [CUR_W-1:0]   RATED_RESET = 32'd16777216;
	localparam logic [CUR_W-1:0]   PEAK_RESET  = 32'd50331648;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 63'd1871704703661;

	// register index, byte address / 8
	typedef enum logic [1:0] {
		REG_RATED = 2'd0,
		REG_PEAK  = 2'd1,
		REG_LIMIT = 2'd2,
		REG_NONE  = 2'd3
	} cop_reg_t;

	typedef struct packed {
		logic [AXIS_W-1:0]          axis;
		logic signed [SAMPLE_W-1:0] current_sample;
	} cop_in_t;

	typedef struct packed {
		logic [AXIS_W-1:0] axis_out;
		logic              peak_fault;
		logic              overload_fault;
		logic [ACC_W-1:0]  load_level;
	} cop_out_t;

	typedef struct packed {
		logic [CUR_W-1:0]   rated_current;
		logic [CUR_W-1:0]   peak_current;
		logic [LIMIT_W-1:0] overload_limit;
	} cop_cfg_t;

	// sample after magnitude, compares and squaring
	typedef struct packed {
		logic [AXIS_W-1:0] axis;
		logic              peak_now;
		logic              over_rated;
		logic [INC_W-1:0]  inc;
	} cop_mid_t;

endpackage

/* rtl/current_overload_peak_monitor_core.sv */
`timescale 1ns / 1ps
// path: an accepted item passes through the stage 1, stage 2 and output registers
// throughput: one item per cycle when out_stall is low; the per-axis accumulator
//   is read and written in stage 2 only, so same-axis items may follow back to back
// reset: arst_n clears all stage valids, the per-axis accumulators and peak
//   flags, and loads the threshold registers with their defaults

module current_overload_peak_monitor_core #(
	parameter int NUM_AXES = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  cop_pkg::cop_in_t           in_data,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output cop_pkg::cop_out_t          out_data,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cop_pkg::APB_AW-1:0] paddr,
	input  logic [cop_pkg::APB_DW-1:0] pwdata,
	output logic [cop_pkg::APB_DW-1:0] prdata,
	output logic                       pready
);
	import cop_pkg::*;

	// stage 1 holds the raw item, stage 2 the squared magnitude and compares,
	// the output register the finished result
	cop_in_t  item_s1;
	logic     valid_s1;
	cop_mid_t mid_s2;
	logic     valid_s2;
	cop_out_t out_q;
	logic     out_valid_q;

	cop_cfg_t cfg;
	cop_mid_t mid_d;
	cop_out_t res_d;

	// each stage takes new data when it is empty or its content moves on
	logic out_ready;
	logic ready_s2;
	logic ready_s1;
	logic adv_s1;
	logic adv_s2;
	logic in_fire;

	assign out_ready = !out_valid_q || !out_stall;
	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign adv_s1    = valid_s1 && ready_s2;
	assign adv_s2    = valid_s2 && out_ready;
	assign in_fire   = in_valid && ready_s1;

	assign in_stall  = !ready_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	cop_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// magnitude, threshold compares and the 32x32 square
	cop_front u_front (
		.item (item_s1),
		.cfg  (cfg),
		.mid  (mid_d)
	);

	// per-axis state; updated exactly when the stage 2 item moves to the output
	cop_accum #(
		.NUM_AXES (NUM_AXES)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv_s2),
		.mid    (mid_s2),
		.cfg    (cfg),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_data;
		end
		if (adv_s1) begin
			mid_s2 <= mid_d;
		end
		if (adv_s2) begin
			out_q <= res_d;
		end
	end

endmodule

/* rtl/cop_regs.sv */
`timescale 1ns / 1ps

module cop_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cop_pkg::APB_AW-1:0] paddr,
	input  logic [cop_pkg::APB_DW-1:0] pwdata,
	output logic [cop_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output cop_pkg::cop_cfg_t          cfg
);
	import cop_pkg::*;

	cop_cfg_t cfg_q;
	cop_reg_t sel;
	logic     wr_en;

	assign sel    = cop_reg_t'(paddr[APB_AW-1:3]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rated_current  <= RATED_RESET;
			cfg_q.peak_current   <= PEAK_RESET;
			cfg_q.overload_limit <= LIMIT_RESET;
		end else if (wr_en) begin
			case (sel)
				REG_RATED: cfg_q.rated_current  <= pwdata[CUR_W-1:0];
				REG_PEAK:  cfg_q.peak_current   <= pwdata[CUR_W-1:0];
				REG_LIMIT: cfg_q.overload_limit <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (sel)
			REG_RATED: prdata = APB_DW'(cfg_q.rated_current);
			REG_PEAK:  prdata = APB_DW'(cfg_q.peak_current);
			REG_LIMIT: prdata = APB_DW'(cfg_q.overload_limit);
			default:   prdata = '0;
		endcase
	end

endmodule

/* rtl/cop_front.sv */
`timescale 1ns / 1ps

module cop_front (
	input  cop_pkg::cop_in_t  item,
	input  cop_pkg::cop_cfg_t cfg,
	output cop_pkg::cop_mid_t mid
);
	import cop_pkg::*;

	logic [CUR_W-1:0]   mag;
	logic [2*CUR_W-1:0] sq;

	// two's complement magnitude; most negative sample gives 2^31 unsigned
	assign mag = item.current_sample[SAMPLE_W-1] ?
		(~item.current_sample + 1'b1) : item.current_sample;
	assign sq  = mag * mag;

	assign mid.axis       = item.axis;
	assign mid.peak_now   = (mag >= cfg.peak_current);
	assign mid.over_rated = (mag > cfg.rated_current);
	assign mid.inc        = sq[2*CUR_W-1:ACC_SHIFT];

endmodule

/* rtl/cop_accum.sv */
`timescale 1ns / 1ps

module cop_accum #(
	parameter int NUM_AXES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  upd,
	input  cop_pkg::cop_mid_t     mid,
	input  cop_pkg::cop_cfg_t     cfg,
	output cop_pkg::cop_out_t     res
);
	import cop_pkg::*;

	localparam int IDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

	logic [ACC_W-1:0] accum_q [NUM_AXES];
	logic             prev_q  [NUM_AXES];

	logic [IDX_W-1:0] idx;
	logic             axis_ok;
	logic [ACC_W-1:0] acc_old;
	logic [ACC_W:0]   sum;
	logic [ACC_W-1:0] acc_new;
	logic             ov;
	logic             pk;
	logic [ACC_W-1:0] acc_next;

	assign axis_ok = (32'(mid.axis) < 32'(NUM_AXES));
	assign idx     = IDX_W'(32'(mid.axis));
	assign acc_old = axis_ok ? accum_q[idx] : '0;
	assign sum     = {1'b0, acc_old} + (ACC_W + 1)'(mid.inc);

	always_comb begin
		if (mid.over_rated) begin
			acc_new = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
		end else begin
			acc_new = acc_old;
		end
		ov       = axis_ok && (acc_new > ACC_W'(cfg.overload_limit));
		pk       = axis_ok && mid.peak_now && !prev_q[idx];
		acc_next = ov ? '0 : acc_new;
	end

	assign res.axis_out       = mid.axis;
	assign res.peak_fault     = pk;
	assign res.overload_fault = ov;
	assign res.load_level     = axis_ok ? acc_next : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				accum_q[i] <= '0;
				prev_q[i]  <= 1'b0;
			end
		end else if (upd && axis_ok) begin
			accum_q[idx] <= acc_next;
			prev_q[idx]  <= mid.peak_now;
		end
	end

endmodule

/* rtl/cop_checker.sv */
`timescale 1ns / 1ps

module cop_checker #(
	parameter int NUM_AXES = 8
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input cop_pkg::cop_out_t          out_data
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed while stalled");

	// an overload fault always comes with a cleared accumulator
	a_ov_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overload_fault |-> out_data.load_level == '0)
		else $error("overload fault with nonzero load level");

	// an axis outside the configured range reports nothing
	a_bad_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (32'(out_data.axis_out) >= 32'(NUM_AXES)) |->
			!out_data.peak_fault && !out_data.overload_fault &&
			out_data.load_level == '0)
		else $error("fault or level reported for unused axis");

	// no result appears unless an item was accepted before it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall) && !out_valid ##1
		!(in_valid && !in_stall) && !out_valid ##1
		!(in_valid && !in_stall) && !out_valid |=> !out_valid)
		else $error("result without an accepted item");

endmodule

bind current_overload_peak_monitor_core cop_checker #(.NUM_AXES(NUM_AXES)) u_cop_checker (.*);
